@@ rtl/efct_pkg.sv @@
// ----------------------------------------------------------------------------
// Encoder frame check package
// Types, constants and the CRC-8 helper shared by the encoder frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package efct_pkg;

  localparam int unsigned PosW      = 18;
  localparam int unsigned FrameW    = 32;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 18;

  localparam logic [7:0]      CRC_POLY          = 8'h97;
  localparam logic [PosW-1:0] POS_HALF          = 18'd131072;
  localparam logic [PosW-1:0] DEFAULT_THRESHOLD = 18'd60000;
  localparam logic [1:0]      DEFAULT_MAX_REJ   = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] REG_POSITION_OFFSET = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_JUMP_THRESHOLD  = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_MAX_REJECTS     = 2'd2;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_ENC_ERR = 2'd2,
    ST_REJECT  = 2'd3
  } status_e;

  typedef struct packed {
    logic [FrameW-1:0] frame_word;
    logic              offset_request;
  } enc_in_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            connected;
    logic [1:0]      frame_status;
  } enc_out_t;

  typedef struct packed {
    logic [PosW-1:0] position_offset;
    logic [PosW-1:0] jump_threshold;
    logic [1:0]      max_rejects;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] held_position;
    logic            link_ok;
    logic [1:0]      reject_count;
    logic            offset_pending;
  } track_t;

  // One data byte through the CRC-8 register, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/encoder_frame_check_and_track.sv @@
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless out_stall_i stalls; the tracking state is
// read and updated in the same cycle that the item leaves for the result register.
// Reset clears both valid flags and the tracking state, and loads the
// configuration registers with offset 0, threshold 60000 and reject limit 2.
// ----------------------------------------------------------------------------
// Encoder frame check and track
// Checks absolute-encoder frames and tracks the offset-corrected position.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_frame_check_and_track (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire efct_pkg::enc_in_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output efct_pkg::enc_out_t                  out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [efct_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [efct_pkg::CfgDataW-1:0]  cfg_data_i
);

  efct_pkg::cfg_t     cfg;
  efct_pkg::track_t   state_q, state_d;
  efct_pkg::status_e  status;
  efct_pkg::enc_in_t  s1_data_q;
  efct_pkg::enc_out_t out_data_q;
  logic               s1_valid_q;
  logic               out_valid_q;
  logic               advance;

  efct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  efct_judge u_judge (
    .item_i   (s1_data_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .status_o (status)
  );

  // The input register drains whenever the result register is free or leaving.
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q.position     <= state_d.held_position;
      out_data_q.connected    <= state_d.link_ok;
      out_data_q.frame_status <= status;
    end
  end

`ifndef SYNTHESIS
  a_accept_connects : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.frame_status == efct_pkg::ST_ACCEPT) |-> out_data_o.connected)
    else $error("accepted frame without connected flag");

  a_crc_disconnects : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.frame_status == efct_pkg::ST_CRC_ERR) |-> !out_data_o.connected)
    else $error("CRC mismatch left encoder connected");

  a_reject_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (status != efct_pkg::ST_ACCEPT) |=>
      $stable(state_q.held_position))
    else $error("position changed on a frame that was not accepted");

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with no item waiting");
`endif

endmodule

`default_nettype wire

@@ rtl/efct_cfg.sv @@
// ----------------------------------------------------------------------------
// Encoder frame check configuration registers
// Holds the position offset, jump threshold and reject limit.
// ----------------------------------------------------------------------------
`default_nettype none

module efct_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [efct_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  wire logic [efct_pkg::CfgDataW-1:0]    cfg_data_i,
  output efct_pkg::cfg_t                        cfg_o
);

  efct_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.position_offset <= '0;
      cfg_q.jump_threshold  <= efct_pkg::DEFAULT_THRESHOLD;
      cfg_q.max_rejects     <= efct_pkg::DEFAULT_MAX_REJ;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        efct_pkg::REG_POSITION_OFFSET: cfg_q.position_offset <= cfg_data_i;
        efct_pkg::REG_JUMP_THRESHOLD:  cfg_q.jump_threshold  <= cfg_data_i;
        efct_pkg::REG_MAX_REJECTS:     cfg_q.max_rejects     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/efct_judge.sv @@
// ----------------------------------------------------------------------------
// Encoder frame judge
// Checks the frame CRC and error bit, and decides on the position update.
// ----------------------------------------------------------------------------
`default_nettype none

module efct_judge (
  input  wire efct_pkg::enc_in_t  item_i,
  input  wire efct_pkg::cfg_t     cfg_i,
  input  wire efct_pkg::track_t   state_i,
  output efct_pkg::track_t        state_o,
  output efct_pkg::status_e       status_o
);

  logic [7:0]                crc0, crc1, crc2;
  logic                      crc_ok;
  logic                      pending;
  logic [efct_pkg::PosW-1:0] raw_pos;
  logic [efct_pkg::PosW-1:0] new_pos;
  logic [efct_pkg::PosW-1:0] delta;
  logic [efct_pkg::PosW-1:0] mag;
  logic                      reject;

  assign crc0    = efct_pkg::crc8_byte(8'h00, item_i.frame_word[31:24]);
  assign crc1    = efct_pkg::crc8_byte(crc0, item_i.frame_word[23:16]);
  assign crc2    = efct_pkg::crc8_byte(crc1, item_i.frame_word[15:8]);
  assign crc_ok  = (~crc2 == item_i.frame_word[7:0]);
  assign pending = state_i.offset_pending | item_i.offset_request;

  assign raw_pos = item_i.frame_word[31:14];
  assign new_pos = raw_pos + cfg_i.position_offset;
  assign delta   = new_pos - state_i.held_position;
  // Shortest-way magnitude; a half-turn difference stays at 2^17.
  assign mag     = (delta <= efct_pkg::POS_HALF) ? delta : ('0 - delta);
  assign reject  = (state_i.reject_count < cfg_i.max_rejects) && !pending &&
                   (mag > cfg_i.jump_threshold);

  always_comb begin
    state_o                = state_i;
    state_o.offset_pending = pending;
    status_o               = efct_pkg::ST_ACCEPT;
    if (!crc_ok) begin
      state_o.link_ok = 1'b0;
      status_o        = efct_pkg::ST_CRC_ERR;
    end else if (!item_i.frame_word[9]) begin
      status_o = efct_pkg::ST_ENC_ERR;
    end else if (reject) begin
      state_o.reject_count = state_i.reject_count + 2'd1;
      status_o             = efct_pkg::ST_REJECT;
    end else begin
      state_o.held_position  = new_pos;
      state_o.link_ok        = 1'b1;
      state_o.reject_count   = '0;
      state_o.offset_pending = 1'b0;
    end
  end

endmodule

`default_nettype wire
